// ===== rtl/lft_pkg.sv =====
// Shared types and constants for the LFU slot table with oldest-first tie-break.
// Used by lft_slot_ram, lft_scan and lfu_table_oldest_tiebreak; no dependencies.
`timescale 1ns / 1ps

package lft_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_BITS  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int OCC_BITS   = $clog2(MAX_SLOTS + 1);
    localparam int KEY_BITS   = 8;
    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS  = 32;
    localparam int CFG_BITS   = 5;

    // Result item layout in m_tdata
    localparam int OUT_BITS   = 1 + 4 + 1 + 8 + 16;
    localparam int OUT_TDATA  = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0]  TIME_MAX  = {TIME_BITS{1'b1}};

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [TIME_BITS-1:0]  ins_time;
        logic [COUNT_BITS-1:0] count;
        logic [KEY_BITS-1:0]   key;
    } entry_t;

    // Outcome of one pass over all slots
    typedef struct packed {
        logic                  hit_found;
        logic [SLOT_BITS-1:0]  hit_slot;
        entry_t                hit_entry;
        logic                  free_found;
        logic [SLOT_BITS-1:0]  free_slot;
        logic                  best_found;
        logic [SLOT_BITS-1:0]  best_slot;
        logic [KEY_BITS-1:0]   best_key;
    } scan_res_t;

endpackage

// ===== rtl/lft_slot_ram.sv =====
// Slot memory: key, use count and insertion time per slot.
// One write port, one read port with registered read data. Uses lft_pkg.
`timescale 1ns / 1ps

module lft_slot_ram (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [lft_pkg::SLOT_BITS-1:0]    wr_addr,
    input  lft_pkg::entry_t                  wr_data,
    input  logic [lft_pkg::SLOT_BITS-1:0]    rd_addr,
    output lft_pkg::entry_t                  rd_data
);

    lft_pkg::entry_t mem [lft_pkg::MAX_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/lft_scan.sv =====
// Scan unit: takes one slot entry per cycle and keeps the hit match, the lowest
// free slot and the best eviction candidate. Uses lft_pkg.
`timescale 1ns / 1ps

module lft_scan (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             clear,
    input  logic                             ent_valid,
    input  logic [lft_pkg::SLOT_BITS-1:0]    ent_idx,
    input  logic                             ent_live,
    input  lft_pkg::entry_t                  ent,
    input  logic [lft_pkg::KEY_BITS-1:0]     req_key,
    output lft_pkg::scan_res_t               res
);

    logic                                 hit_found_reg;
    logic [lft_pkg::SLOT_BITS-1:0]        hit_slot_reg;
    lft_pkg::entry_t                      hit_entry_reg;
    logic                                 free_found_reg;
    logic [lft_pkg::SLOT_BITS-1:0]        free_slot_reg;
    logic                                 best_found_reg;
    logic [lft_pkg::SLOT_BITS-1:0]        best_slot_reg;
    lft_pkg::entry_t                      best_entry_reg;

    logic match;
    logic better;

    assign match = ent_live && (ent.key == req_key);

    // lower count first, then older insertion, then lower key
    always_comb begin
        if (ent.count != best_entry_reg.count) begin
            better = ent.count < best_entry_reg.count;
        end else if (ent.ins_time != best_entry_reg.ins_time) begin
            better = ent.ins_time < best_entry_reg.ins_time;
        end else begin
            better = ent.key < best_entry_reg.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end else if (ent_valid) begin
            if (match && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
            end
            if (!ent_live && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
            if (ent_live && (!best_found_reg || better)) begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ent_valid && !clear) begin
            if (match && !hit_found_reg) begin
                hit_slot_reg  <= ent_idx;
                hit_entry_reg <= ent;
            end
            if (!ent_live && !free_found_reg) begin
                free_slot_reg <= ent_idx;
            end
            if (ent_live && (!best_found_reg || better)) begin
                best_slot_reg  <= ent_idx;
                best_entry_reg <= ent;
            end
        end
    end

    always_comb begin
        res.hit_found  = hit_found_reg;
        res.hit_slot   = hit_slot_reg;
        res.hit_entry  = hit_entry_reg;
        res.free_found = free_found_reg;
        res.free_slot  = free_slot_reg;
        res.best_found = best_found_reg;
        res.best_slot  = best_slot_reg;
        res.best_key   = best_entry_reg.key;
    end

endmodule

// ===== rtl/lfu_table_oldest_tiebreak.sv =====
// LFU slot table with oldest-first tie-break: top level with control and result register.
// Instantiates lft_slot_ram and lft_scan; uses lft_pkg.
`timescale 1ns / 1ps

// Usage:
//   s_ channel: one request item per key (s_tdata[7:0] = req_key).
//   m_ channel: one result item per request, in request order.
//   cfg channel: writes active_slots (cfg_data); cfg_ready is always high.
//   Write it only while no request is in flight.
// Timing: a request is taken only while the block is idle. It then reads
//   all 16 slots from the slot memory, one read a cycle, compares each entry
//   in the scan unit, and writes the updated entry back in the final step.
//   The states run ST_SCAN, ST_LAST and then ST_FINISH, where the result
//   item is registered.
// The result sits in an output register; a new request is accepted while it
//   waits. If the receiver still holds off when the next scan finishes, the
//   block waits in its final step until the register frees.
// Reset (aresetn low, synchronous) empties the table, clears the item time
//   and occupancy, and sets active_slots to 16. No clearing pass is needed.
module lfu_table_oldest_tiebreak (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lft_pkg::CFG_BITS-1:0]      cfg_data,    // active_slots
    // requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,     // [7:0] req_key
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] was_hit, [4:1] slot_used, [5] did_evict, [13:6] victim_key,
    // [29:14] use_count, rest zero
    output logic [lft_pkg::OUT_TDATA-1:0]     m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    localparam logic [lft_pkg::SLOT_BITS-1:0] LAST_IDX =
        lft_pkg::SLOT_BITS'(lft_pkg::MAX_SLOTS - 1);
    localparam logic [lft_pkg::OCC_BITS-1:0] OCC_MAX =
        lft_pkg::OCC_BITS'(lft_pkg::MAX_SLOTS);

    state_t                              state_reg, state_next;
    logic [lft_pkg::SLOT_BITS-1:0]       idx_reg;
    logic                                rd_pend_reg;
    logic [lft_pkg::SLOT_BITS-1:0]       rd_idx_reg;
    logic [lft_pkg::KEY_BITS-1:0]        key_reg;
    logic [lft_pkg::MAX_SLOTS-1:0]       valid_reg;
    logic [lft_pkg::OCC_BITS-1:0]        occ_reg;
    logic [lft_pkg::TIME_BITS-1:0]       time_reg;
    logic [lft_pkg::CFG_BITS-1:0]        limit_cfg_reg;
    logic                                m_tvalid_reg;
    logic [lft_pkg::OUT_TDATA-1:0]       m_tdata_reg;

    lft_pkg::entry_t                     rd_data;
    lft_pkg::entry_t                     wr_data;
    lft_pkg::scan_res_t                  scan;

    logic                                s_fire;
    logic                                fin_fire;
    logic [lft_pkg::OCC_BITS-1:0]        limit;
    logic                                full;
    logic                                evict;
    logic [lft_pkg::SLOT_BITS-1:0]       slot;
    logic [lft_pkg::COUNT_BITS-1:0]      new_count;
    logic [lft_pkg::OCC_BITS-1:0]        occ_next;
    logic [7:0]                          victim_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign fin_fire  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (fin_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    lft_slot_ram u_ram (
        .aclk    (aclk),
        .wr_en   (fin_fire),
        .wr_addr (slot),
        .wr_data (wr_data),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    lft_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (s_fire),
        .ent_valid (rd_pend_reg),
        .ent_idx   (rd_idx_reg),
        .ent_live  (valid_reg[rd_idx_reg]),
        .ent       (rd_data),
        .req_key   (key_reg),
        .res       (scan)
    );

    // effective limit: 0 acts as 1, above the table size acts as the table size
    always_comb begin
        if (limit_cfg_reg == '0) begin
            limit = lft_pkg::OCC_BITS'(1);
        end else if (lft_pkg::OCC_BITS'(limit_cfg_reg) > OCC_MAX) begin
            limit = OCC_MAX;
        end else begin
            limit = lft_pkg::OCC_BITS'(limit_cfg_reg);
        end
    end

    assign full = occ_reg >= limit;

    // Write-back decision. The memory is written only in the final step and
    // read only during the scan, so accesses never overlap.
    always_comb begin
        evict      = 1'b0;
        victim_out = '0;
        occ_next   = occ_reg;
        new_count  = lft_pkg::COUNT_BITS'(1);
        wr_data.key      = key_reg;
        wr_data.count    = lft_pkg::COUNT_BITS'(1);
        wr_data.ins_time = time_reg;
        if (scan.hit_found) begin
            slot = scan.hit_slot;
            if (scan.hit_entry.count != lft_pkg::COUNT_MAX) begin
                new_count = scan.hit_entry.count + lft_pkg::COUNT_BITS'(1);
            end else begin
                new_count = scan.hit_entry.count;
            end
            wr_data.count    = new_count;
            wr_data.ins_time = scan.hit_entry.ins_time;
        end else if (full) begin
            if (scan.best_found) begin
                slot       = scan.best_slot;
                evict      = 1'b1;
                victim_out = 8'(scan.best_key);
            end else begin
                slot     = '0;
                occ_next = lft_pkg::OCC_BITS'(1);
            end
        end else begin
            slot     = scan.free_slot;
            occ_next = occ_reg + lft_pkg::OCC_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            time_reg      <= '0;
            limit_cfg_reg <= lft_pkg::CFG_BITS'(16);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN);
            if (s_fire) begin
                idx_reg <= '0;
            end else if (state_reg == ST_SCAN) begin
                idx_reg <= idx_reg + lft_pkg::SLOT_BITS'(1);
            end
            if (cfg_valid) begin
                limit_cfg_reg <= cfg_data;
            end
            if (fin_fire) begin
                valid_reg[slot] <= 1'b1;
                occ_reg         <= occ_next;
                if (time_reg != lft_pkg::TIME_MAX) begin
                    time_reg <= time_reg + lft_pkg::TIME_BITS'(1);
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= idx_reg;
        if (s_fire) begin
            key_reg <= s_tdata[lft_pkg::KEY_BITS-1:0];
        end
        if (fin_fire) begin
            m_tdata_reg <= lft_pkg::OUT_TDATA'({
                (scan.hit_found ? new_count : lft_pkg::COUNT_BITS'(1)),
                victim_out,
                evict,
                4'(slot),
                scan.hit_found
            });
        end
    end

`ifndef SYNTHESIS
    // occupancy tracks the number of filled slots exactly
    a_occ_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == lft_pkg::OCC_BITS'($countones(valid_reg)))
        else $error("occupancy out of step with slot valid bits");

    // the slot reported in a fresh result holds a live entry
    a_slot_live: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_fire |=> valid_reg[m_tdata_reg[4:1]])
        else $error("reported slot is not valid");

    // an eviction only happens with every slot of the limit in use
    a_evict_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && evict) |-> (occ_reg >= limit && !scan.hit_found))
        else $error("eviction without a full table");

    // a miss below the limit always finds a free slot
    a_free_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (fin_fire && !scan.hit_found && !full) |-> scan.free_found)
        else $error("no free slot below the limit");
`endif

endmodule
